@@ rtl/cbp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_pkg
// Shared types, widths, register codes and the microprogram of the cascaded
// balance controller.
// ----------------------------------------------------------------------------
package cbp_pkg;

  // field and datapath widths
  localparam int DATA_W       = 16;
  localparam int DRIVE_W      = 24;
  localparam int INT_W        = 18;
  localparam int OPND_W       = 25;
  localparam int PROD_W       = DATA_W + OPND_W;
  localparam int ACC_W        = 48;
  localparam int STEP_W       = 5;
  localparam int CFG_ADDR_W   = 5;
  localparam int CFG_DATA_W   = 32;

  // loop dividers and their tick counter widths
  localparam int ANGLE_DIVIDE = 5;
  localparam int SPEED_DIVIDE = 50;
  localparam int ANGLE_TICK_W = 3;
  localparam int SPEED_TICK_W = 6;

  // speed integral clamp, +-500.0 in q8.8
  localparam logic signed [INT_W-1:0] INT_LIMIT = 18'sd128000;

  // register reset values
  localparam logic signed [DATA_W-1:0] RST_RATE_KP     = -16'sd678;
  localparam logic signed [DATA_W-1:0] RST_RATE_KD     = -16'sd291;
  localparam logic signed [DATA_W-1:0] RST_ANGLE_KP    = -16'sd3200;
  localparam logic signed [DATA_W-1:0] RST_ANGLE_KD    = -16'sd2048;
  localparam logic signed [DATA_W-1:0] RST_SPEED_KP    = 16'sd6226;
  localparam logic signed [DATA_W-1:0] RST_SPEED_KI    = 16'sd5033;
  localparam logic signed [DATA_W-1:0] RST_UPRIGHT_SET = 16'sd852;

  typedef enum logic [2:0] {
    REG_RATE_KP     = 3'd0,
    REG_RATE_KD     = 3'd1,
    REG_ANGLE_KP    = 3'd2,
    REG_ANGLE_KD    = 3'd3,
    REG_SPEED_KP    = 3'd4,
    REG_SPEED_KI    = 3'd5,
    REG_UPRIGHT_SET = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] rate_kp;
    logic signed [DATA_W-1:0] rate_kd;
    logic signed [DATA_W-1:0] angle_kp;
    logic signed [DATA_W-1:0] angle_kd;
    logic signed [DATA_W-1:0] speed_kp;
    logic signed [DATA_W-1:0] speed_ki;
    logic signed [DATA_W-1:0] upright_set;
  } cfg_regs_t;

  // microcode fields
  typedef enum logic [2:0] {
    ALU_NONE,
    ALU_INT,
    ALU_BIAS,
    ALU_ERR,
    ALU_DIFF
  } alu_op_t;

  typedef enum logic [2:0] {
    GAIN_RATE_KP,
    GAIN_RATE_KD,
    GAIN_ANGLE_KP,
    GAIN_ANGLE_KD,
    GAIN_SPEED_KP,
    GAIN_SPEED_KI
  } gain_sel_t;

  typedef enum logic [2:0] {
    OPND_SPEED,
    OPND_INT,
    OPND_T,
    OPND_RATE,
    OPND_ERR
  } opnd_sel_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_LOAD_SH8,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    WB_NONE,
    WB_SPEED,
    WB_ANGLE,
    WB_DRIVE
  } wb_op_t;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_NO_SPEED,
    JMP_NO_ANGLE
  } jmp_t;

  typedef struct packed {
    alu_op_t           alu;
    logic              mul_en;
    gain_sel_t         gain;
    opnd_sel_t         opnd;
    acc_op_t           acc;
    wb_op_t            wb;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
    logic              emit;
    logic              updated;
  } ctrl_word_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // program entry points
  localparam logic [STEP_W-1:0] STEP_START = 5'd0;
  localparam logic [STEP_W-1:0] STEP_ANGLE = 5'd6;
  localparam logic [STEP_W-1:0] STEP_RATE  = 5'd12;
  localparam logic [STEP_W-1:0] STEP_EMIT  = 5'd17;

  localparam ctrl_word_t UCODE_NOP = '{
    alu:     ALU_NONE,
    mul_en:  1'b0,
    gain:    GAIN_RATE_KP,
    opnd:    OPND_SPEED,
    acc:     ACC_NONE,
    wb:      WB_NONE,
    jmp:     JMP_NEXT,
    target:  STEP_START,
    emit:    1'b0,
    updated: 1'b0
  };

  // control store: speed loop, angle loop, rate loop, then result
  function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_word_t cw;
    cw = UCODE_NOP;
    unique case (step)
      5'd0: begin
        cw.jmp    = JMP_NO_SPEED;
        cw.target = STEP_ANGLE;
      end
      5'd1: begin
        cw.alu = ALU_INT;
      end
      5'd2: begin
        cw.mul_en = 1'b1;
        cw.gain   = GAIN_SPEED_KP;
        cw.opnd   = OPND_SPEED;
      end
      5'd3: begin
        cw.mul_en = 1'b1;
        cw.gain   = GAIN_SPEED_KI;
        cw.opnd   = OPND_INT;
        cw.acc    = ACC_LOAD_SH8;
      end
      5'd4: begin
        cw.acc = ACC_ADD;
      end
      5'd5: begin
        cw.wb = WB_SPEED;
      end
      5'd6: begin
        cw.jmp    = JMP_NO_ANGLE;
        cw.target = STEP_RATE;
      end
      5'd7: begin
        cw.alu = ALU_BIAS;
      end
      5'd8: begin
        cw.mul_en = 1'b1;
        cw.gain   = GAIN_ANGLE_KP;
        cw.opnd   = OPND_T;
      end
      5'd9: begin
        cw.mul_en = 1'b1;
        cw.gain   = GAIN_ANGLE_KD;
        cw.opnd   = OPND_RATE;
        cw.acc    = ACC_LOAD;
      end
      5'd10: begin
        cw.acc = ACC_ADD;
      end
      5'd11: begin
        cw.wb = WB_ANGLE;
      end
      5'd12: begin
        cw.alu = ALU_ERR;
      end
      5'd13: begin
        cw.alu    = ALU_DIFF;
        cw.mul_en = 1'b1;
        cw.gain   = GAIN_RATE_KP;
        cw.opnd   = OPND_ERR;
      end
      5'd14: begin
        cw.mul_en = 1'b1;
        cw.gain   = GAIN_RATE_KD;
        cw.opnd   = OPND_T;
        cw.acc    = ACC_LOAD;
      end
      5'd15: begin
        cw.acc = ACC_ADD;
      end
      5'd16: begin
        cw.wb = WB_DRIVE;
      end
      5'd17: begin
        cw.emit = 1'b1;
      end
      default: begin
        cw.emit = 1'b1;
      end
    endcase
    return cw;
  endfunction

endpackage

@@ rtl/cascaded_balance_pid_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_balance_pid_core
// Three-loop cascaded balance controller (speed pi, angle p plus rate
// damping, rate pd) in q8.8 fixed point, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// One request is one control tick. A small control store of eighteen steps
// drives a single 16x25 signed multiplier, a 48-bit accumulator and one
// round-and-saturate unit; the step counter skips the speed section unless
// this is a 50th tick and the angle section unless this is a 5th tick.
// A running tick runs the speed and angle sections when they are due, then
// the rate loop and the result step; a tick with run_enable low goes
// straight to the result step and returns the held drive with
// updated low. The microprogram runs over the shared multiplier, and
// one request is in flight at a time. The result
// sits in an output register so the next request is taken while it waits.
// Gains and the setpoint are written over the cfg_ port at byte address
// 4*index, 16 bits sign-extended on read; change them only while idle.
// ----------------------------------------------------------------------------
module cascaded_balance_pid_core (
  input  logic                               clk,
  input  logic                               rst_n,
  // tick request
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [cbp_pkg::DATA_W-1:0]  in_roll_angle,
  input  logic signed [cbp_pkg::DATA_W-1:0]  in_roll_rate,
  input  logic signed [cbp_pkg::DATA_W-1:0]  in_wheel_speed,
  input  logic                               in_run_enable,
  // drive result
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [cbp_pkg::DRIVE_W-1:0] out_drive,
  output logic                               out_updated,
  // configuration port
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [cbp_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [cbp_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [cbp_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                               cfg_pready
);
  import cbp_pkg::*;

  cfg_regs_t  cfg;
  ctrl_word_t ctrl;
  logic       in_load;

  // gains and setpoint
  cbp_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // step counter, control store and tick dividers
  cbp_sequencer u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_run_enable (in_run_enable),
    .in_stall      (in_stall),
    .in_load       (in_load),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .ctrl          (ctrl)
  );

  // shared multiply-accumulate datapath and loop state
  cbp_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_load        (in_load),
    .in_roll_angle  (in_roll_angle),
    .in_roll_rate   (in_roll_rate),
    .in_wheel_speed (in_wheel_speed),
    .cfg            (cfg),
    .ctrl           (ctrl),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_drive      (out_drive),
    .out_updated    (out_updated)
  );

endmodule

@@ rtl/cbp_cfg_regs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_cfg_regs
// Register bank for loop gains and setpoint, written and read over an
// apb-style port.
// ----------------------------------------------------------------------------
module cbp_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [cbp_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [cbp_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [cbp_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready,
  output cbp_pkg::cfg_regs_t              cfg
);
  import cbp_pkg::*;

  cfg_regs_t                regs_r;
  cfg_regs_t                regs_nxt;
  logic                     wr_en;
  reg_idx_t                 idx;
  logic signed [DATA_W-1:0] wdata;
  logic signed [DATA_W-1:0] rdata;

  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign idx        = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign wdata      = cfg_pwdata[DATA_W-1:0];
  assign cfg_pready = 1'b1;
  assign cfg        = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      unique case (idx)
        REG_RATE_KP:     regs_nxt.rate_kp     = wdata;
        REG_RATE_KD:     regs_nxt.rate_kd     = wdata;
        REG_ANGLE_KP:    regs_nxt.angle_kp    = wdata;
        REG_ANGLE_KD:    regs_nxt.angle_kd    = wdata;
        REG_SPEED_KP:    regs_nxt.speed_kp    = wdata;
        REG_SPEED_KI:    regs_nxt.speed_ki    = wdata;
        REG_UPRIGHT_SET: regs_nxt.upright_set = wdata;
        default:         regs_nxt             = regs_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_RATE_KP:     rdata = regs_r.rate_kp;
      REG_RATE_KD:     rdata = regs_r.rate_kd;
      REG_ANGLE_KP:    rdata = regs_r.angle_kp;
      REG_ANGLE_KD:    rdata = regs_r.angle_kd;
      REG_SPEED_KP:    rdata = regs_r.speed_kp;
      REG_SPEED_KI:    rdata = regs_r.speed_ki;
      REG_UPRIGHT_SET: rdata = regs_r.upright_set;
      default:         rdata = '0;
    endcase
    cfg_prdata = CFG_DATA_W'(rdata);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.rate_kp     <= RST_RATE_KP;
      regs_r.rate_kd     <= RST_RATE_KD;
      regs_r.angle_kp    <= RST_ANGLE_KP;
      regs_r.angle_kd    <= RST_ANGLE_KD;
      regs_r.speed_kp    <= RST_SPEED_KP;
      regs_r.speed_ki    <= RST_SPEED_KI;
      regs_r.upright_set <= RST_UPRIGHT_SET;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

@@ rtl/cbp_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_sequencer
// Step counter over the control store, loop tick counters and the request
// handshake on the input side.
// ----------------------------------------------------------------------------
module cbp_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_run_enable,
  output logic                in_stall,
  output logic                in_load,
  input  logic                out_valid,
  input  logic                out_stall,
  output cbp_pkg::ctrl_word_t ctrl
);
  import cbp_pkg::*;

  seq_state_t              state_r;
  seq_state_t              state_nxt;
  logic [STEP_W-1:0]       step_r;
  logic [STEP_W-1:0]       step_nxt;
  logic [ANGLE_TICK_W-1:0] angle_tick_r;
  logic [ANGLE_TICK_W-1:0] angle_tick_nxt;
  logic [SPEED_TICK_W-1:0] speed_tick_r;
  logic [SPEED_TICK_W-1:0] speed_tick_nxt;
  logic                    angle_go_r;
  logic                    angle_go_nxt;
  logic                    speed_go_r;
  logic                    speed_go_nxt;
  logic                    run_r;
  logic [ANGLE_TICK_W-1:0] angle_inc;
  logic [SPEED_TICK_W-1:0] speed_inc;
  ctrl_word_t              rom_word;
  logic                    out_free;
  logic                    fire;

  localparam logic [ANGLE_TICK_W-1:0] ANGLE_DIV = ANGLE_TICK_W'(ANGLE_DIVIDE);
  localparam logic [SPEED_TICK_W-1:0] SPEED_DIV = SPEED_TICK_W'(SPEED_DIVIDE);

  assign rom_word = ucode_rom(step_r);
  assign out_free = !out_valid || !out_stall;
  assign fire     = (state_r == SEQ_RUN) && rom_word.emit && out_free;
  assign in_load  = in_valid && (state_r == SEQ_IDLE);

  // tick counters saturate at their divider, a running loop clears its own
  always_comb begin
    angle_inc      = (angle_tick_r < ANGLE_DIV) ? angle_tick_r + 1'b1 : angle_tick_r;
    speed_inc      = (speed_tick_r < SPEED_DIV) ? speed_tick_r + 1'b1 : speed_tick_r;
    angle_go_nxt   = in_run_enable && (angle_inc == ANGLE_DIV);
    speed_go_nxt   = in_run_enable && (speed_inc == SPEED_DIV);
    angle_tick_nxt = angle_go_nxt ? '0 : angle_inc;
    speed_tick_nxt = speed_go_nxt ? '0 : speed_inc;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEQ_IDLE: if (in_load) state_nxt = SEQ_RUN;
      SEQ_RUN:  if (fire)    state_nxt = SEQ_IDLE;
      default:  state_nxt = SEQ_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = (state_r != SEQ_IDLE);
    ctrl         = (state_r == SEQ_RUN) ? rom_word : UCODE_NOP;
    ctrl.emit    = fire;
    ctrl.updated = run_r;
  end

  always_comb begin
    step_nxt = step_r;
    priority if (in_load) begin
      step_nxt = in_run_enable ? STEP_START : STEP_EMIT;
    end else if (state_r == SEQ_RUN && !rom_word.emit) begin
      unique case (rom_word.jmp)
        JMP_NEXT:     step_nxt = step_r + 1'b1;
        JMP_NO_SPEED: step_nxt = speed_go_r ? step_r + 1'b1 : rom_word.target;
        JMP_NO_ANGLE: step_nxt = angle_go_r ? step_r + 1'b1 : rom_word.target;
        default:      step_nxt = STEP_EMIT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= SEQ_IDLE;
      step_r       <= STEP_START;
      angle_tick_r <= '0;
      speed_tick_r <= '0;
      angle_go_r   <= 1'b0;
      speed_go_r   <= 1'b0;
      run_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      if (in_load) begin
        angle_tick_r <= angle_tick_nxt;
        speed_tick_r <= speed_tick_nxt;
        angle_go_r   <= angle_go_nxt;
        speed_go_r   <= speed_go_nxt;
        run_r        <= in_run_enable;
      end
    end
  end

  a_ticks_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (angle_tick_r <= ANGLE_DIV) && (speed_tick_r <= SPEED_DIV))
    else $error("tick counter beyond its divider");

  a_load_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_load |=> (state_r == SEQ_RUN))
    else $error("accepted request did not start the program");

  a_step_in_program: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SEQ_RUN) |-> (step_r <= STEP_EMIT))
    else $error("step counter left the program");

endmodule

@@ rtl/cbp_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_datapath
// Shared multiplier, accumulator, rounding and saturation, loop state and
// the result register.
// ----------------------------------------------------------------------------
module cbp_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_load,
  input  logic signed [cbp_pkg::DATA_W-1:0]  in_roll_angle,
  input  logic signed [cbp_pkg::DATA_W-1:0]  in_roll_rate,
  input  logic signed [cbp_pkg::DATA_W-1:0]  in_wheel_speed,
  input  cbp_pkg::cfg_regs_t                 cfg,
  input  cbp_pkg::ctrl_word_t                ctrl,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic signed [cbp_pkg::DRIVE_W-1:0] out_drive,
  output logic                               out_updated
);
  import cbp_pkg::*;

  localparam logic signed [ACC_W-1:0] HALF8     = ACC_W'(128);
  localparam logic signed [ACC_W-1:0] HALF24    = ACC_W'(8388608);
  localparam logic signed [ACC_W-1:0] MAX16     = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] MIN16     = -ACC_W'(32768);
  localparam logic signed [ACC_W-1:0] MAX24     = ACC_W'(8388607);
  localparam logic signed [ACC_W-1:0] MIN24     = -ACC_W'(8388608);
  localparam logic signed [OPND_W-1:0] ERR_MAX  = OPND_W'(8388607);
  localparam logic signed [OPND_W-1:0] ERR_MIN  = -OPND_W'(8388608);

  // captured request
  logic signed [DATA_W-1:0]  angle_r;
  logic signed [DATA_W-1:0]  rate_r;
  logic signed [DATA_W-1:0]  speed_r;

  // loop state
  logic signed [INT_W-1:0]   integral_r;
  logic signed [INT_W-1:0]   integral_nxt;
  logic signed [DATA_W-1:0]  speed_out_r;
  logic signed [DRIVE_W-1:0] angle_out_r;
  logic signed [DRIVE_W-1:0] last_err_r;
  logic signed [DRIVE_W-1:0] drive_hold_r;

  // working registers
  logic signed [DRIVE_W-1:0] err_r;
  logic signed [DRIVE_W-1:0] err_nxt;
  logic signed [OPND_W-1:0]  t_r;
  logic signed [OPND_W-1:0]  t_nxt;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  prod_nxt;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [ACC_W-1:0]   acc_nxt;

  logic                      out_valid_r;
  logic                      out_valid_nxt;
  logic signed [DRIVE_W-1:0] out_drive_r;
  logic                      out_updated_r;

  logic signed [DATA_W-1:0]  gain_a;
  logic signed [OPND_W-1:0]  opnd_b;
  logic signed [INT_W:0]     int_sum;
  logic signed [OPND_W-1:0]  err_raw;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   rnd_sum;
  logic signed [ACC_W-1:0]   rnd;
  logic signed [DATA_W-1:0]  rnd_sat16;
  logic signed [DRIVE_W-1:0] rnd_sat24;

  assign out_valid   = out_valid_r;
  assign out_drive   = out_drive_r;
  assign out_updated = out_updated_r;

  // multiplier operands
  always_comb begin
    unique case (ctrl.gain)
      GAIN_RATE_KP:  gain_a = cfg.rate_kp;
      GAIN_RATE_KD:  gain_a = cfg.rate_kd;
      GAIN_ANGLE_KP: gain_a = cfg.angle_kp;
      GAIN_ANGLE_KD: gain_a = cfg.angle_kd;
      GAIN_SPEED_KP: gain_a = cfg.speed_kp;
      GAIN_SPEED_KI: gain_a = cfg.speed_ki;
      default:       gain_a = '0;
    endcase
    unique case (ctrl.opnd)
      OPND_SPEED: opnd_b = OPND_W'(speed_r);
      OPND_INT:   opnd_b = OPND_W'(integral_r);
      OPND_T:     opnd_b = t_r;
      OPND_RATE:  opnd_b = OPND_W'(rate_r);
      OPND_ERR:   opnd_b = OPND_W'(err_r);
      default:    opnd_b = '0;
    endcase
    prod_nxt = PROD_W'(gain_a) * PROD_W'(opnd_b);
  end

  // pre-multiply arithmetic
  always_comb begin
    int_sum = (INT_W+1)'(integral_r) + (INT_W+1)'(speed_r);
    if (int_sum > (INT_W+1)'(INT_LIMIT)) begin
      integral_nxt = INT_LIMIT;
    end else if (int_sum < -(INT_W+1)'(INT_LIMIT)) begin
      integral_nxt = -INT_LIMIT;
    end else begin
      integral_nxt = int_sum[INT_W-1:0];
    end

    err_raw = OPND_W'(rate_r) - OPND_W'(angle_out_r);
    if (err_raw > ERR_MAX) begin
      err_nxt = ERR_MAX[DRIVE_W-1:0];
    end else if (err_raw < ERR_MIN) begin
      err_nxt = ERR_MIN[DRIVE_W-1:0];
    end else begin
      err_nxt = err_raw[DRIVE_W-1:0];
    end

    if (ctrl.alu == ALU_BIAS) begin
      t_nxt = OPND_W'(angle_r) - OPND_W'(cfg.upright_set) - OPND_W'(speed_out_r);
    end else begin
      t_nxt = OPND_W'(err_r) - OPND_W'(last_err_r);
    end
  end

  // accumulator
  always_comb begin
    prod_ext = ACC_W'(prod_r);
    unique case (ctrl.acc)
      ACC_NONE:     acc_nxt = acc_r;
      ACC_LOAD:     acc_nxt = prod_ext;
      ACC_LOAD_SH8: acc_nxt = prod_ext <<< 8;
      ACC_ADD:      acc_nxt = acc_r + prod_ext;
      default:      acc_nxt = acc_r;
    endcase
  end

  // round half up, then saturate
  always_comb begin
    rnd_sum = acc_r + ((ctrl.wb == WB_SPEED) ? HALF24 : HALF8);
    rnd     = (ctrl.wb == WB_SPEED) ? (rnd_sum >>> 24) : (rnd_sum >>> 8);
    if (rnd > MAX16) begin
      rnd_sat16 = MAX16[DATA_W-1:0];
    end else if (rnd < MIN16) begin
      rnd_sat16 = MIN16[DATA_W-1:0];
    end else begin
      rnd_sat16 = rnd[DATA_W-1:0];
    end
    if (rnd > MAX24) begin
      rnd_sat24 = MAX24[DRIVE_W-1:0];
    end else if (rnd < MIN24) begin
      rnd_sat24 = MIN24[DRIVE_W-1:0];
    end else begin
      rnd_sat24 = rnd[DRIVE_W-1:0];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (ctrl.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_load) begin
      angle_r <= in_roll_angle;
      rate_r  <= in_roll_rate;
      speed_r <= in_wheel_speed;
    end
    if (ctrl.alu == ALU_BIAS || ctrl.alu == ALU_DIFF) begin
      t_r <= t_nxt;
    end
    if (ctrl.alu == ALU_ERR) begin
      err_r <= err_nxt;
    end
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
    acc_r <= acc_nxt;
    if (ctrl.emit) begin
      out_drive_r   <= drive_hold_r;
      out_updated_r <= ctrl.updated;
    end
  end

  // loop state and result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r   <= '0;
      speed_out_r  <= '0;
      angle_out_r  <= '0;
      last_err_r   <= '0;
      drive_hold_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (ctrl.alu == ALU_INT) begin
        integral_r <= integral_nxt;
      end
      unique case (ctrl.wb)
        WB_NONE:  ;
        WB_SPEED: speed_out_r <= rnd_sat16;
        WB_ANGLE: angle_out_r <= rnd_sat24;
        WB_DRIVE: begin
          drive_hold_r <= rnd_sat24;
          last_err_r   <= err_r;
        end
        default:  ;
      endcase
    end
  end

  a_integral_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (integral_r <= INT_LIMIT) && (integral_r >= -INT_LIMIT))
    else $error("speed integral outside its clamp");

  a_err_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.wb == WB_DRIVE) |=> (last_err_r == $past(err_r)))
    else $error("rate error not carried to the next tick");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit |=> (out_valid_r && out_drive_r == $past(drive_hold_r)))
    else $error("result register missed the drive value");

endmodule
